// ===== design/lalc_pkg.sv =====
// ============================================================================
// lalc_pkg
// Shared types and constants for the averaged light level classifier.
// ============================================================================
package lalc_pkg;

    // Default window shape
    localparam int WINDOW_LEN_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int IN_BITS    = 12;   // sample port
    localparam int AVG_BITS   = 12;   // average port
    localparam int CFG_BITS   = 12;   // band edge registers
    localparam int CMP_BITS   = 16;   // compare width, covers samples up to 16 bits
    localparam int ADDR_BITS  = 5;    // eight word slots, five registers used
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = ADDR_BITS - 2;

    // Register reset values
    localparam logic [CFG_BITS-1:0] LIGHT_UPPER_RST  = 12'd1200;
    localparam logic [CFG_BITS-1:0] MEDIUM_LOWER_RST = 12'd1400;
    localparam logic [CFG_BITS-1:0] MEDIUM_UPPER_RST = 12'd2400;
    localparam logic [CFG_BITS-1:0] DARK_LOWER_RST   = 12'd2600;
    localparam logic [CFG_BITS-1:0] FULL_SCALE_RST   = 12'd4095;

    typedef enum logic [1:0] {
        LVL_LIGHT  = 2'd0,
        LVL_MEDIUM = 2'd1,
        LVL_DARK   = 2'd2
    } level_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_LIGHT_UPPER  = 3'd0,
        REG_MEDIUM_LOWER = 3'd1,
        REG_MEDIUM_UPPER = 3'd2,
        REG_DARK_LOWER   = 3'd3,
        REG_FULL_SCALE   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] light_upper;
        logic [CFG_BITS-1:0] medium_lower;
        logic [CFG_BITS-1:0] medium_upper;
        logic [CFG_BITS-1:0] dark_lower;
        logic [CFG_BITS-1:0] full_scale;
    } cfg_t;

endpackage

// ===== design/lalc_regs.sv =====
// ============================================================================
// lalc_regs
// APB register file holding the five band edge registers.
// ============================================================================
module lalc_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lalc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lalc_pkg::DATA_BITS-1:0] pwdata,
    output logic [lalc_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output lalc_pkg::cfg_t                 cfg
);

    lalc_pkg::cfg_t     cfg_reg;
    lalc_pkg::cfg_t     cfg_next;
    lalc_pkg::reg_idx_t idx;
    logic               wr_en;
    logic [lalc_pkg::CFG_BITS-1:0] wr_val;
    logic [lalc_pkg::CFG_BITS-1:0] rd_val;

    assign idx    = lalc_pkg::reg_idx_t'(paddr[lalc_pkg::ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign wr_val = pwdata[lalc_pkg::CFG_BITS-1:0];
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                lalc_pkg::REG_LIGHT_UPPER:  cfg_next.light_upper  = wr_val;
                lalc_pkg::REG_MEDIUM_LOWER: cfg_next.medium_lower = wr_val;
                lalc_pkg::REG_MEDIUM_UPPER: cfg_next.medium_upper = wr_val;
                lalc_pkg::REG_DARK_LOWER:   cfg_next.dark_lower   = wr_val;
                lalc_pkg::REG_FULL_SCALE:   cfg_next.full_scale   = wr_val;
                default:                    cfg_next = cfg_reg;  // unmapped
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lalc_pkg::REG_LIGHT_UPPER:  rd_val = cfg_reg.light_upper;
            lalc_pkg::REG_MEDIUM_LOWER: rd_val = cfg_reg.medium_lower;
            lalc_pkg::REG_MEDIUM_UPPER: rd_val = cfg_reg.medium_upper;
            lalc_pkg::REG_DARK_LOWER:   rd_val = cfg_reg.dark_lower;
            lalc_pkg::REG_FULL_SCALE:   rd_val = cfg_reg.full_scale;
            default:                    rd_val = '0;
        endcase
    end

    assign prdata = lalc_pkg::DATA_BITS'(rd_val);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_upper  <= lalc_pkg::LIGHT_UPPER_RST;
            cfg_reg.medium_lower <= lalc_pkg::MEDIUM_LOWER_RST;
            cfg_reg.medium_upper <= lalc_pkg::MEDIUM_UPPER_RST;
            cfg_reg.dark_lower   <= lalc_pkg::DARK_LOWER_RST;
            cfg_reg.full_scale   <= lalc_pkg::FULL_SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/lalc_window.sv =====
// ============================================================================
// lalc_window
// Sample delay line and running window sum; the sum is the stage-1 register.
// ============================================================================
module lalc_window
#(
    parameter int WINDOW_LEN  = lalc_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = lalc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic [SUM_BITS-1:0]    sum
);

    // tap 0 newest, last tap is the sample that drops out next
    logic [SAMPLE_BITS-1:0] taps_reg [WINDOW_LEN];
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;

    assign sum_next = sum_reg - SUM_BITS'(taps_reg[WINDOW_LEN-1])
                              + SUM_BITS'(sample_in);
    assign sum      = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            sum_reg     <= sum_next;
            taps_reg[0] <= sample_in;
            for (int i = 1; i < WINDOW_LEN; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
    end

endmodule

// ===== design/lalc_classify.sv =====
// ============================================================================
// lalc_classify
// Divides the window sum by the window length and applies the level bands.
// ============================================================================
module lalc_classify
#(
    parameter int WINDOW_LEN  = lalc_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = lalc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [SUM_BITS-1:0]           sum,
    input  lalc_pkg::cfg_t                cfg,
    output lalc_pkg::level_t              level,
    output logic [lalc_pkg::AVG_BITS-1:0] average
);

    // floor(x / N) == (x * ceil(2^K / N)) >> K, exact for x < 2^SUM_BITS
    localparam int SHIFT    = SUM_BITS + $clog2(WINDOW_LEN);
    localparam int RECIP_W  = SUM_BITS + 1;
    localparam int PROD_W   = SUM_BITS + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic [PROD_W-1:0]              prod;
    logic [SAMPLE_BITS-1:0]         quot;
    logic [lalc_pkg::CMP_BITS-1:0]  avg_c;
    logic [lalc_pkg::CMP_BITS-1:0]  lu;
    logic [lalc_pkg::CMP_BITS-1:0]  ml;
    logic [lalc_pkg::CMP_BITS-1:0]  mu;
    logic [lalc_pkg::CMP_BITS-1:0]  dl;
    logic [lalc_pkg::CMP_BITS-1:0]  fs;
    lalc_pkg::level_t               level_reg;
    lalc_pkg::level_t               level_next;
    logic [lalc_pkg::AVG_BITS-1:0]  avg_reg;

    assign prod  = PROD_W'(sum) * PROD_W'(RECIP);
    assign quot  = prod[SHIFT +: SAMPLE_BITS];
    assign avg_c = lalc_pkg::CMP_BITS'(quot);
    assign lu    = lalc_pkg::CMP_BITS'(cfg.light_upper);
    assign ml    = lalc_pkg::CMP_BITS'(cfg.medium_lower);
    assign mu    = lalc_pkg::CMP_BITS'(cfg.medium_upper);
    assign dl    = lalc_pkg::CMP_BITS'(cfg.dark_lower);
    assign fs    = lalc_pkg::CMP_BITS'(cfg.full_scale);

    // first matching test wins
    always_comb
    begin
        priority if (avg_c <= lu)
            level_next = lalc_pkg::LVL_LIGHT;
        else if (avg_c >= ml && avg_c <= mu)
            level_next = lalc_pkg::LVL_MEDIUM;
        else if (avg_c >= dl && avg_c <= fs)
            level_next = lalc_pkg::LVL_DARK;
        else if (avg_c > lu && avg_c < ml &&
                 level_reg != lalc_pkg::LVL_LIGHT && level_reg != lalc_pkg::LVL_MEDIUM)
            level_next = lalc_pkg::LVL_LIGHT;
        else if (avg_c > mu && avg_c < dl &&
                 level_reg != lalc_pkg::LVL_MEDIUM && level_reg != lalc_pkg::LVL_DARK)
            level_next = lalc_pkg::LVL_MEDIUM;
        else
            level_next = level_reg;
    end

    // level register doubles as the hysteresis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= lalc_pkg::LVL_DARK;
        end
        else if (load)
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            avg_reg <= lalc_pkg::AVG_BITS'(quot);
        end
    end

    assign level   = level_reg;
    assign average = avg_reg;

endmodule

// ===== design/averaged_light_level_classifier.sv =====
// ============================================================================
// averaged_light_level_classifier
// Moving-average light level detector with hysteresis between bands.
// ============================================================================
// Each request carries one light-sensor sample. The block keeps the last
// WINDOW_LEN samples (zero after reset) and their running sum, and returns
// one result per request: the truncated window average and the level
// (0 light, 1 medium, 2 dark) after that sample. Averages between bands keep
// the previous level, except that dark in the light/medium gap becomes light
// and light in the medium/dark gap becomes medium; the level is dark after
// reset. The edge that accepts the request updates the delay line and
// running sum; once the result register is free, a later edge divides by
// the window length (a constant reciprocal multiply), classifies and
// loads the result register. One
// request per cycle is sustained; in_ready drops only while both the sum
// stage and the result register are full and out_ready is low. Band edge
// registers sit on the APB port at byte offsets 0x00 light_upper,
// 0x04 medium_lower, 0x08 medium_upper, 0x0C dark_lower, 0x10 full_scale,
// 12 bits each; write them only while no request is in flight.
// ============================================================================
module averaged_light_level_classifier
#(
    parameter int WINDOW_LEN  = lalc_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = lalc_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    // sample requests
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lalc_pkg::IN_BITS-1:0]   sample,

    // results
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     level,
    output logic [lalc_pkg::AVG_BITS-1:0]  average,

    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lalc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lalc_pkg::DATA_BITS-1:0] pwdata,
    output logic [lalc_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LEN);

    lalc_pkg::cfg_t         cfg;
    lalc_pkg::level_t       lvl;
    logic [SUM_BITS-1:0]    sum;
    logic [SAMPLE_BITS-1:0] sample_in;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_take;     // request accepted into the sum stage
    logic s2_load;     // sum stage moves into the result register

    // bits above SAMPLE_BITS are dropped, narrower samples zero-extend
    assign sample_in = SAMPLE_BITS'(sample);

    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    lalc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lalc_window
    #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    )
    u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_take),
        .sample_in (sample_in),
        .sum       (sum)
    );

    lalc_classify
    #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    )
    u_classify
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (s2_load),
        .sum     (sum),
        .cfg     (cfg),
        .level   (lvl),
        .average (average)
    );

    assign level     = lvl;
    assign out_valid = out_valid_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the averaged light level classifier.
// ============================================================================
// A clocked driver feeds sample requests from a queue and a clocked monitor
// checks every result against a bench-side model. The model tracks the
// 8-entry sample window, the running sum and the band and hysteresis rules.
// Band edges are rewritten over APB between phases, and only once the block
// has drained. Each phase reads the edges back. Both handshakes idle at
// random, and the output side holds off once for a long stretch.
// ============================================================================
module tb;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int WIN_LEN       = lalc_pkg::WINDOW_LEN_DEF;
    localparam int SUM_BITS      = lalc_pkg::IN_BITS + $clog2(WIN_LEN);
    localparam int NUM_REGS      = 5;
    localparam int ADDR_SLOTS    = 1 << lalc_pkg::IDX_BITS;
    localparam int SETTLE_CYCLES = 6;     // settle margin after the last result
    localparam int PHASE_ITEMS   = 180;
    localparam int NUM_PHASES    = 8;
    localparam int IDLE_PCT      = 12;
    localparam int HOLD_AT       = 300;   // requests sent before the long stall
    localparam int HOLD_CYCLES   = 150;
    localparam int QUIET_LO      = 700;   // window with no random idling
    localparam int QUIET_HI      = 950;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 100;
    localparam logic [lalc_pkg::IN_BITS-1:0] SAMPLE_MAX = '1;
    // lands the average at 150 when the rest of the window is empty
    localparam logic [lalc_pkg::IN_BITS-1:0] GAP_PROBE  = 12'd1200;

    typedef enum int {
        PLAN_RESET,
        PLAN_ZERO,
        PLAN_FULL,
        PLAN_ORDERED,
        PLAN_SCRAMBLED,
        PLAN_LOW_CEILING,
        PLAN_WIDE_GAPS
    } band_plan_t;

    typedef struct packed {
        lalc_pkg::level_t              lvl;
        logic [lalc_pkg::AVG_BITS-1:0] avg;
    } light_reading_t;

    // DUT ports, all inputs known from time zero
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [lalc_pkg::IN_BITS-1:0]   sample    = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [1:0]                     level;
    logic [lalc_pkg::AVG_BITS-1:0]  average;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [lalc_pkg::ADDR_BITS-1:0] paddr     = '0;
    logic [lalc_pkg::DATA_BITS-1:0] pwdata    = '0;
    logic [lalc_pkg::DATA_BITS-1:0] prdata;
    logic                           pready;

    // bench copy of the block state and band edges
    logic [lalc_pkg::IN_BITS-1:0]   win_samples [WIN_LEN];
    int unsigned                    win_slot;
    logic [SUM_BITS-1:0]            win_sum;
    lalc_pkg::level_t               cur_level;
    lalc_pkg::cfg_t                 band_edges;

    logic [lalc_pkg::IN_BITS-1:0]   pending_samples [$];
    light_reading_t                 expected_readings [$];
    light_reading_t                 want_reading;

    int                   samples_queued   = 0;
    int                   samples_sent     = 0;
    int                   readings_seen    = 0;
    int                   error_count      = 0;
    int                   reg_writes       = 0;
    int                   settings_applied = 0;
    int                   hold_left        = 0;
    logic                 hold_done        = 1'b0;
    int                   cycle_count      = 0;

    averaged_light_level_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .level     (level),
        .average   (average),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Light level prediction: push one sample into the window, then
    // classify the truncated average. Bands are tested in order light,
    // medium, dark. Averages in a gap keep the level, except that dark
    // falling into the light/medium gap snaps to light and light rising
    // into the medium/dark gap snaps to medium. Anything above full_scale
    // or caught by crossed edges keeps the level.
    // ------------------------------------------------------------------
    function automatic light_reading_t advance_light_window(
        input logic [lalc_pkg::IN_BITS-1:0] s);
        light_reading_t                r;
        logic [lalc_pkg::AVG_BITS-1:0] avg;
        lalc_pkg::level_t              nxt;
        win_sum = win_sum - SUM_BITS'(win_samples[win_slot]) + SUM_BITS'(s);
        win_samples[win_slot] = s;
        win_slot = (win_slot + 1) % WIN_LEN;
        avg = lalc_pkg::AVG_BITS'(win_sum / WIN_LEN);
        if (avg <= band_edges.light_upper)
            nxt = lalc_pkg::LVL_LIGHT;
        else if (avg >= band_edges.medium_lower && avg <= band_edges.medium_upper)
            nxt = lalc_pkg::LVL_MEDIUM;
        else if (avg >= band_edges.dark_lower && avg <= band_edges.full_scale)
            nxt = lalc_pkg::LVL_DARK;
        else if (avg > band_edges.light_upper && avg < band_edges.medium_lower &&
                 cur_level != lalc_pkg::LVL_LIGHT && cur_level != lalc_pkg::LVL_MEDIUM)
            nxt = lalc_pkg::LVL_LIGHT;
        else if (avg > band_edges.medium_upper && avg < band_edges.dark_lower &&
                 cur_level != lalc_pkg::LVL_MEDIUM && cur_level != lalc_pkg::LVL_DARK)
            nxt = lalc_pkg::LVL_MEDIUM;
        else
            nxt = cur_level;
        cur_level = nxt;
        r.lvl = nxt;
        r.avg = avg;
        return r;
    endfunction

    function automatic void note_error(input string what, input int unsigned want,
                                       input int unsigned got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        else if (error_count == MAX_REPORTS + 1)
            $display("%0t ns: further mismatches not shown", $time);
    endfunction

    function automatic void queue_sample(input logic [lalc_pkg::IN_BITS-1:0] v);
        pending_samples.push_back(v);
        samples_queued++;
    endfunction

    function automatic logic [lalc_pkg::IN_BITS-1:0] clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > int'(SAMPLE_MAX))
            return SAMPLE_MAX;
        return lalc_pkg::IN_BITS'(v);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. The prediction is taken at acceptance, so the order
    // of expected readings always follows the order of accepted requests.
    // Valid stays up with the same sample until the handshake completes.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_readings.push_back(advance_light_window(sample));
                samples_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 &&
                    ((samples_sent >= QUIET_LO && samples_sent < QUIET_HI) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    sample   <= pending_samples.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long output stall. Requests keep coming, so the block has to
    // fill up and drop in_ready.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && samples_sent >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: field-by-field compare against the oldest expected
    // reading.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                readings_seen++;
                if (expected_readings.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: result with no request pending, level %0d average %0d",
                             $time, level, average);
                end
                else
                begin
                    want_reading = expected_readings.pop_front();
                    if (level !== want_reading.lvl)
                        note_error("level", want_reading.lvl, level);
                    if (average !== want_reading.avg)
                        note_error("average", want_reading.avg, average);
                end
            end
            out_ready <= (hold_left == 0) &&
                         ((readings_seen >= QUIET_LO && readings_seen < QUIET_HI) ||
                          $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: run stopped after %0d cycles, %0d of %0d results seen",
                     $time, cycle_count, readings_seen, samples_queued);
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // APB access. The register is written at the edge that ends the access
    // phase. Upper data bits carry junk, and the block must keep only the
    // low 12. Indexes past the last register must leave all edges alone.
    // ------------------------------------------------------------------
    task automatic write_band_reg(input int idx,
                                  input logic [lalc_pkg::CFG_BITS-1:0] val);
        logic [lalc_pkg::DATA_BITS-1:0] word;
        word = $urandom;
        word[lalc_pkg::CFG_BITS-1:0] = val;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lalc_pkg::ADDR_BITS'(idx * 4);
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lalc_pkg::REG_LIGHT_UPPER:  band_edges.light_upper  = val;
            lalc_pkg::REG_MEDIUM_LOWER: band_edges.medium_lower = val;
            lalc_pkg::REG_MEDIUM_UPPER: band_edges.medium_upper = val;
            lalc_pkg::REG_DARK_LOWER:   band_edges.dark_lower   = val;
            lalc_pkg::REG_FULL_SCALE:   band_edges.full_scale   = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic check_band_reg(input int idx);
        logic [lalc_pkg::CFG_BITS-1:0] want;
        case (idx)
            lalc_pkg::REG_LIGHT_UPPER:  want = band_edges.light_upper;
            lalc_pkg::REG_MEDIUM_LOWER: want = band_edges.medium_lower;
            lalc_pkg::REG_MEDIUM_UPPER: want = band_edges.medium_upper;
            lalc_pkg::REG_DARK_LOWER:   want = band_edges.dark_lower;
            default:                    want = band_edges.full_scale;
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= lalc_pkg::ADDR_BITS'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[lalc_pkg::CFG_BITS-1:0] !== want)
            note_error("register read", want, prdata[lalc_pkg::CFG_BITS-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_band_edges(input lalc_pkg::cfg_t c);
        write_band_reg(lalc_pkg::REG_LIGHT_UPPER,  c.light_upper);
        write_band_reg(lalc_pkg::REG_MEDIUM_LOWER, c.medium_lower);
        write_band_reg(lalc_pkg::REG_MEDIUM_UPPER, c.medium_upper);
        write_band_reg(lalc_pkg::REG_DARK_LOWER,   c.dark_lower);
        write_band_reg(lalc_pkg::REG_FULL_SCALE,   c.full_scale);
        for (int i = NUM_REGS; i < ADDR_SLOTS; i++)
            write_band_reg(i, lalc_pkg::CFG_BITS'($urandom));
        for (int i = 0; i < NUM_REGS; i++)
            check_band_reg(i);
        settings_applied++;
    endtask

    // Every result has come back, and the block has had time to go idle.
    // Config writes happen only after this.
    task automatic wait_for_drain();
        while (readings_seen < samples_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic lalc_pkg::cfg_t pick_band_edges(input band_plan_t plan);
        logic [lalc_pkg::CFG_BITS-1:0] e [NUM_REGS];
        logic [lalc_pkg::CFG_BITS-1:0] t;
        lalc_pkg::cfg_t                c;
        for (int i = 0; i < NUM_REGS; i++)
            e[i] = lalc_pkg::CFG_BITS'($urandom);
        if (plan != PLAN_SCRAMBLED)
        begin
            for (int i = 0; i < NUM_REGS - 1; i++)
                for (int j = 0; j < NUM_REGS - 1 - i; j++)
                    if (e[j] > e[j+1])
                    begin
                        t      = e[j];
                        e[j]   = e[j+1];
                        e[j+1] = t;
                    end
        end
        c = {e[0], e[1], e[2], e[3], e[4]};
        case (plan)
            PLAN_RESET:
            begin
                c.light_upper  = lalc_pkg::LIGHT_UPPER_RST;
                c.medium_lower = lalc_pkg::MEDIUM_LOWER_RST;
                c.medium_upper = lalc_pkg::MEDIUM_UPPER_RST;
                c.dark_lower   = lalc_pkg::DARK_LOWER_RST;
                c.full_scale   = lalc_pkg::FULL_SCALE_RST;
            end
            PLAN_ZERO: c = '0;
            PLAN_FULL: c = '1;
            // the dark band holds at most dark_lower itself: nothing above it can read as dark
            PLAN_LOW_CEILING: c.full_scale = lalc_pkg::CFG_BITS'($urandom_range(e[3]));
            PLAN_WIDE_GAPS:
            begin
                c.light_upper  = lalc_pkg::CFG_BITS'($urandom_range(600));
                c.medium_lower = lalc_pkg::CFG_BITS'($urandom_range(1600, 1200));
                c.medium_upper = lalc_pkg::CFG_BITS'($urandom_range(2000, 1600));
                c.dark_lower   = lalc_pkg::CFG_BITS'($urandom_range(3600, 2800));
                c.full_scale   = lalc_pkg::CFG_BITS'($urandom_range(4095, 3600));
            end
            default: ;
        endcase
        return c;
    endfunction

    // Mostly whole-window sequences: steady windows parked on or next to an
    // edge (exact boundary averages), ramps that sweep through bands and gaps,
    // and full-scale/zero bursts. The rest is single random samples.
    task automatic queue_random_samples(input int count);
        int start;
        int target;
        int step;
        int kind;
        start = samples_queued;
        while (samples_queued - start < count)
        begin
            kind = $urandom_range(9);
            if (kind < 4)
            begin
                case (int'($urandom_range(NUM_REGS - 1)))
                    lalc_pkg::REG_LIGHT_UPPER:  target = band_edges.light_upper;
                    lalc_pkg::REG_MEDIUM_LOWER: target = band_edges.medium_lower;
                    lalc_pkg::REG_MEDIUM_UPPER: target = band_edges.medium_upper;
                    lalc_pkg::REG_DARK_LOWER:   target = band_edges.dark_lower;
                    default:                    target = band_edges.full_scale;
                endcase
                target += int'($urandom_range(2)) - 1;
                repeat (WIN_LEN) queue_sample(clamp_sample(target));
            end
            else if (kind < 6)
            begin
                target = $urandom_range(SAMPLE_MAX);
                step   = int'($urandom_range(1024)) - 512;
                repeat (WIN_LEN)
                begin
                    queue_sample(clamp_sample(target));
                    target += step;
                end
            end
            else if (kind == 6)
            begin
                repeat (WIN_LEN) queue_sample($urandom_range(1) ? SAMPLE_MAX : '0);
            end
            else
            begin
                queue_sample(lalc_pkg::IN_BITS'($urandom_range(SAMPLE_MAX)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        band_plan_t     plans [NUM_PHASES];
        lalc_pkg::cfg_t c;
        plans = '{PLAN_RESET, PLAN_ORDERED, PLAN_ZERO, PLAN_SCRAMBLED,
                  PLAN_FULL, PLAN_LOW_CEILING, PLAN_WIDE_GAPS, PLAN_ORDERED};

        for (int i = 0; i < WIN_LEN; i++)
            win_samples[i] = '0;
        win_slot  = 0;
        win_sum   = '0;
        cur_level = lalc_pkg::LVL_DARK;
        band_edges.light_upper  = lalc_pkg::LIGHT_UPPER_RST;
        band_edges.medium_lower = lalc_pkg::MEDIUM_LOWER_RST;
        band_edges.medium_upper = lalc_pkg::MEDIUM_UPPER_RST;
        band_edges.dark_lower   = lalc_pkg::DARK_LOWER_RST;
        band_edges.full_scale   = lalc_pkg::FULL_SCALE_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // edges must come out of reset at their defaults
        for (int i = 0; i < NUM_REGS; i++)
            check_band_reg(i);

        // Default edges, window empty and level dark. A zero sample drops
        // straight to light. Full-scale samples then climb through every band.
        // The medium/dark gap holds medium on the way up.
        queue_sample('0);
        repeat (WIN_LEN - 1) queue_sample(SAMPLE_MAX);
        wait_for_drain();

        // Tight bands: light <= 100, medium 200..300, dark 3500..3800.
        c.light_upper  = 12'd100;
        c.medium_lower = 12'd200;
        c.medium_upper = 12'd300;
        c.dark_lower   = 12'd3500;
        c.full_scale   = 12'd3800;
        apply_band_edges(c);
        // full window at 4095 sits above full_scale: level kept dark
        queue_sample(SAMPLE_MAX);
        // sliding down through the medium/dark gap keeps dark
        repeat (WIN_LEN - 1) queue_sample('0);
        // dark landing in the light/medium gap snaps to light
        queue_sample(GAP_PROBE);
        // light jumping into the medium/dark gap snaps to medium
        queue_sample(SAMPLE_MAX);
        wait_for_drain();

        // Random phases, one band plan each. Each drain before the next
        // config write also pauses the sender until every result is back.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apply_band_edges(pick_band_edges(plans[p]));
            queue_random_samples(PHASE_ITEMS);
            wait_for_drain();
        end

        if (expected_readings.size() != 0)
            $display("%0t ns: %0d expected results never arrived",
                     $time, expected_readings.size());
        $display("covered %0d samples under %0d band settings with %0d register writes",
                 samples_sent, settings_applied + 1, reg_writes);
        $display("incl. band gaps, edge-parked windows, stray/wide writes, a %0d-cycle stall",
                 HOLD_CYCLES);
        if (error_count == 0 && expected_readings.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lalc_pkg.sv
design/lalc_regs.sv
design/lalc_window.sv
design/lalc_classify.sv
design/averaged_light_level_classifier.sv
tb/tb.sv
